// File: rtl/core/aidc_pkg.sv
// Shared types, constants and helpers for the accessory ID ADC classifier.
package aidc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int RUN_BITS    = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_mv_t;

  localparam sample_mv_t MV_NEAR_ZERO = sample_mv_t'(100);
  localparam sample_mv_t MHL_WIN_LO   = sample_mv_t'(776);
  localparam sample_mv_t MHL_WIN_HI   = sample_mv_t'(1020);
  localparam sample_mv_t HEADSET_LO   = sample_mv_t'(370);
  localparam sample_mv_t HEADSET_HI   = sample_mv_t'(440);
  localparam sample_mv_t DESK_LO      = sample_mv_t'(550);
  localparam sample_mv_t DESK_HI      = sample_mv_t'(900);

  localparam logic [RUN_BITS-1:0]    SETTLE_RESET   = RUN_BITS'(3);
  localparam sample_mv_t             CAR_LOW_RESET  = sample_mv_t'(150);
  localparam sample_mv_t             CAR_HIGH_RESET = sample_mv_t'(235);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SETTLE_COUNT  = 3'd0,
    CFG_ADC_DETECT_EN = 3'd1,
    CFG_MHL_OVERRIDE  = 3'd2,
    CFG_MHL_SUPPORTED = 3'd3,
    CFG_HOST_SUPPORTED = 3'd4,
    CFG_CAR_WIN_LOW   = 3'd5,
    CFG_CAR_WIN_HIGH  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACC_UNDOCKED = 3'd0,
    ACC_DESK     = 3'd1,
    ACC_CAR      = 3'd2,
    ACC_HEADSET  = 3'd3,
    ACC_MHL      = 3'd4,
    ACC_HOST     = 3'd5,
    ACC_UNDEF    = 3'd6
  } accessory_t;

  typedef enum logic [1:0] {
    LINE_USB   = 2'd0,
    LINE_AUDIO = 2'd1,
    LINE_MHL   = 2'd2
  } path_t;

  typedef enum logic [1:0] {
    HOST_NONE = 2'd0,
    HOST_ON   = 2'd1,
    HOST_OFF  = 2'd2
  } host_t;

  typedef struct packed {
    logic [RUN_BITS-1:0] settle_count;
    logic                adc_detect_enable;
    logic                mhl_override;
    logic                mhl_supported;
    logic                host_supported;
    sample_mv_t          car_window_low;
    sample_mv_t          car_window_high;
  } cfg_t;

  typedef struct packed {
    logic       id_pin;
    logic       redetect;
    logic       adc_valid;
    sample_mv_t adc_mv;
    logic       mhl_adc_valid;
    sample_mv_t mhl_adc_mv;
  } sample_t;

  typedef struct packed {
    logic       settled;
    accessory_t accessory;
    logic       path_write;
    path_t      path_select;
    host_t      host_mode_change;
    logic       irq_rearm;
    logic       irq_active_high;
  } result_t;

  typedef struct packed {
    accessory_t accessory;
    logic       restore_usb;
    logic       host_off;
  } removal_t;

  // Removal rules: headset restores the usb path, host drops host mode,
  // mhl is sticky, everything else just clears.
  function automatic removal_t remove_acc(accessory_t cur);
    removal_t r;
    r.accessory   = ACC_UNDOCKED;
    r.restore_usb = 1'b0;
    r.host_off    = 1'b0;
    unique case (cur)
      ACC_HEADSET: r.restore_usb = 1'b1;
      ACC_HOST:    r.host_off = 1'b1;
      ACC_MHL:     r.accessory = ACC_MHL;
      default:     r.accessory = ACC_UNDOCKED;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/aidc_classify.sv
// Voltage window sort of one detection sample into an accessory class.
module aidc_classify import aidc_pkg::*; (
  input  sample_t    sample,
  input  cfg_t       cfg,
  output accessory_t cls
);

  logic in_mhl_win;

  assign in_mhl_win = sample.mhl_adc_valid && (sample.mhl_adc_mv >= MHL_WIN_LO) &&
                      (sample.mhl_adc_mv <= MHL_WIN_HI);

  always_comb begin
    if (sample.id_pin && !sample.redetect) begin
      cls = ACC_UNDOCKED;
    end else if (!sample.adc_valid) begin
      cls = ACC_UNDEF;
    end else if (sample.adc_mv < MV_NEAR_ZERO) begin
      if (cfg.mhl_override || in_mhl_win) begin
        cls = cfg.mhl_supported ? ACC_MHL : ACC_UNDEF;
      end else begin
        cls = cfg.host_supported ? ACC_HOST : ACC_UNDEF;
      end
    end else if (sample.adc_mv > cfg.car_window_low &&
                 sample.adc_mv < cfg.car_window_high) begin
      cls = ACC_CAR;
    end else if (sample.adc_mv > HEADSET_LO && sample.adc_mv < HEADSET_HI) begin
      cls = ACC_HEADSET;
    end else if (sample.adc_mv > DESK_LO && sample.adc_mv < DESK_HI) begin
      cls = ACC_DESK;
    end else begin
      cls = ACC_UNDEF;
    end
  end

endmodule

// File: rtl/core/aidc_tracker.sv
// Debounce counter and stored accessory state with insert/removal rules.
module aidc_tracker import aidc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cfg_t       cfg,
  input  accessory_t cls,
  input  logic       id_pin,
  output result_t    result
);

  accessory_t          previous_class;
  logic [RUN_BITS-1:0] stable_run;
  accessory_t          current_accessory;
  path_t               last_path;

  logic [RUN_BITS-1:0] run_base;
  logic [RUN_BITS-1:0] stable_run_next;
  logic                settle_ok;
  accessory_t          cls_eff;
  accessory_t          accessory_next;
  path_t               last_path_next;
  logic                path_wr;
  host_t               host_chg;
  removal_t            rem;

  always_comb begin
    run_base        = (stable_run >= cfg.settle_count) ? '0 : stable_run;
    stable_run_next = (cls == previous_class) ? run_base + RUN_BITS'(1) : '0;
    settle_ok       = cfg.adc_detect_enable ? (stable_run_next >= cfg.settle_count) : 1'b1;
    cls_eff         = cfg.adc_detect_enable ? cls : ACC_UNDOCKED;
  end

  always_comb begin
    accessory_next = current_accessory;
    last_path_next = last_path;
    path_wr        = 1'b0;
    host_chg       = HOST_NONE;
    rem            = remove_acc(current_accessory);
    if (settle_ok) begin
      // stale accessory goes first, or undocked removes it
      if (cls_eff == ACC_UNDOCKED || current_accessory != ACC_UNDOCKED) begin
        accessory_next = rem.accessory;
        if (rem.restore_usb) begin
          last_path_next = LINE_USB;
          path_wr        = 1'b1;
        end
        if (rem.host_off) begin
          host_chg = HOST_OFF;
        end
      end
      if (cls_eff != ACC_UNDOCKED) begin
        accessory_next = cls_eff;
      end
      unique case (cls_eff)
        ACC_HEADSET: begin
          last_path_next = LINE_AUDIO;
          path_wr        = 1'b1;
        end
        ACC_MHL: begin
          last_path_next = LINE_MHL;
          path_wr        = 1'b1;
        end
        ACC_HOST: host_chg = HOST_ON;
        default: ;
      endcase
    end
  end

  always_comb begin
    result.settled          = settle_ok;
    result.accessory        = accessory_next;
    result.path_write       = path_wr;
    result.path_select      = last_path_next;
    result.host_mode_change = host_chg;
    result.irq_rearm        = settle_ok && (accessory_next != ACC_MHL);
    result.irq_active_high  = settle_ok && (accessory_next != ACC_MHL) &&
                              ((accessory_next != ACC_UNDOCKED) || !id_pin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_class    <= ACC_UNDOCKED;
      stable_run        <= '0;
      current_accessory <= ACC_UNDOCKED;
      last_path         <= LINE_USB;
    end else if (step) begin
      if (cfg.adc_detect_enable) begin
        previous_class <= cls;
        stable_run     <= stable_run_next;
      end
      current_accessory <= accessory_next;
      last_path         <= last_path_next;
    end
  end

endmodule

// File: rtl/core/accessory_id_adc_classifier.sv
// Top level of the accessory ID ADC classifier: registers, handshakes and checks.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   in       | in_valid / in_ready       | id_pin redetect adc_valid adc_mv mhl_adc_*
//   out      | out_valid / out_ready     | settled accessory path_* host_mode_change irq_*
//   cfg      | cfg_write (no wait)       | cfg_index cfg_data
//
// One transaction per cycle unless out stalls; input and result are both registered.
// The input register feeds the classifier and state update in one pass into the
// result register. Stalls on out hold the result; in stays ready while the input
// register can move on. Reset is synchronous and restores the register defaults.
module accessory_id_adc_classifier import aidc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     id_pin,
  input  logic                     redetect,
  input  logic                     adc_valid,
  input  logic [SAMPLE_BITS-1:0]   adc_mv,
  input  logic                     mhl_adc_valid,
  input  logic [SAMPLE_BITS-1:0]   mhl_adc_mv,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     settled,
  output logic [2:0]               accessory,
  output logic                     path_write,
  output logic [1:0]               path_select,
  output logic [1:0]               host_mode_change,
  output logic                     irq_rearm,
  output logic                     irq_active_high
);

  cfg_t       cfg;
  sample_t    sample;
  logic       sample_valid;
  logic       advance;
  accessory_t cls;
  result_t    result_next;
  result_t    result;

  assign advance  = sample_valid && (!out_valid || out_ready);
  assign in_ready = !sample_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_count      <= SETTLE_RESET;
      cfg.adc_detect_enable <= 1'b1;
      cfg.mhl_override      <= 1'b0;
      cfg.mhl_supported     <= 1'b1;
      cfg.host_supported    <= 1'b1;
      cfg.car_window_low    <= CAR_LOW_RESET;
      cfg.car_window_high   <= CAR_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SETTLE_COUNT:   cfg.settle_count      <= cfg_data[RUN_BITS-1:0];
        CFG_ADC_DETECT_EN:  cfg.adc_detect_enable <= cfg_data[0];
        CFG_MHL_OVERRIDE:   cfg.mhl_override      <= cfg_data[0];
        CFG_MHL_SUPPORTED:  cfg.mhl_supported     <= cfg_data[0];
        CFG_HOST_SUPPORTED: cfg.host_supported    <= cfg_data[0];
        CFG_CAR_WIN_LOW:    cfg.car_window_low    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_CAR_WIN_HIGH:   cfg.car_window_high   <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      sample_valid <= 1'b1;
    end else if (advance) begin
      sample_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      sample.id_pin        <= id_pin;
      sample.redetect      <= redetect;
      sample.adc_valid     <= adc_valid;
      sample.adc_mv        <= adc_mv;
      sample.mhl_adc_valid <= mhl_adc_valid;
      sample.mhl_adc_mv    <= mhl_adc_mv;
    end
  end

  aidc_classify u_classify (
    .sample (sample),
    .cfg    (cfg),
    .cls    (cls)
  );

  aidc_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg),
    .cls    (cls),
    .id_pin (sample.id_pin),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign settled          = result.settled;
  assign accessory        = result.accessory;
  assign path_write       = result.path_write;
  assign path_select      = result.path_select;
  assign host_mode_change = result.host_mode_change;
  assign irq_rearm        = result.irq_rearm;
  assign irq_active_high  = result.irq_active_high;

  a_unsettled_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !settled |-> !path_write && host_mode_change == HOST_NONE && !irq_rearm)
    else $error("unsettled transaction carries side effects");

  a_rearm_vs_mhl: assert property (@(posedge clk) disable iff (rst)
    out_valid && settled |-> irq_rearm == (accessory != ACC_MHL))
    else $error("interrupt rearm disagrees with stored accessory");

  a_mhl_path: assert property (@(posedge clk) disable iff (rst)
    out_valid && accessory == ACC_MHL |-> path_select == LINE_MHL)
    else $error("mhl stored without mhl path");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

endmodule

// File: verif/tb_accessory_id_adc_classifier.sv
// Self-checking testbench for the accessory ID ADC classifier: directed rows, then random runs.
module tb_accessory_id_adc_classifier import aidc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1150;

  localparam result_t IDLE_RESULT =
    '{1'b0, ACC_UNDOCKED, 1'b0, LINE_USB, HOST_NONE, 1'b0, 1'b0};
  localparam result_t UNDOCKED_PIN_HIGH =
    '{1'b1, ACC_UNDOCKED, 1'b0, LINE_USB, HOST_NONE, 1'b1, 1'b0};

  typedef struct {
    bit          is_reg;
    cfg_idx_t    idx;
    int unsigned val;
    sample_t     smp;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  sample_t                  drive;
  logic                     out_valid;
  logic                     out_ready;
  logic                     settled;
  logic [2:0]               accessory;
  logic                     path_write;
  logic [1:0]               path_select;
  logic [1:0]               host_mode_change;
  logic                     irq_rearm;
  logic                     irq_active_high;

  // predictor state
  cfg_t regs = '{SETTLE_RESET, 1'b1, 1'b0, 1'b1, 1'b1, CAR_LOW_RESET, CAR_HIGH_RESET};
  accessory_t prev_cls = ACC_UNDOCKED;
  accessory_t cur_acc  = ACC_UNDOCKED;
  logic [RUN_BITS-1:0] run_len = '0;
  path_t last_path = LINE_USB;
  logic  step_pw;
  host_t step_hm;

  result_t due_reports[$];
  int      mismatches = 0;
  int      issued = 0;
  bit      in_burst = 1'b0;

  accessory_id_adc_classifier i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .id_pin           (drive.id_pin),
    .redetect         (drive.redetect),
    .adc_valid        (drive.adc_valid),
    .adc_mv           (drive.adc_mv),
    .mhl_adc_valid    (drive.mhl_adc_valid),
    .mhl_adc_mv       (drive.mhl_adc_mv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .settled          (settled),
    .accessory        (accessory),
    .path_write       (path_write),
    .path_select      (path_select),
    .host_mode_change (host_mode_change),
    .irq_rearm        (irq_rearm),
    .irq_active_high  (irq_active_high)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic accessory_t id_class(sample_t s);
    if (s.id_pin && !s.redetect) return ACC_UNDOCKED;
    if (!s.adc_valid) return ACC_UNDEF;
    if (s.adc_mv < MV_NEAR_ZERO) begin
      if (regs.mhl_override || (s.mhl_adc_valid && s.mhl_adc_mv >= MHL_WIN_LO &&
                                s.mhl_adc_mv <= MHL_WIN_HI))
        return regs.mhl_supported ? ACC_MHL : ACC_UNDEF;
      return regs.host_supported ? ACC_HOST : ACC_UNDEF;
    end
    if (s.adc_mv > regs.car_window_low && s.adc_mv < regs.car_window_high) return ACC_CAR;
    if (s.adc_mv > HEADSET_LO && s.adc_mv < HEADSET_HI) return ACC_HEADSET;
    if (s.adc_mv > DESK_LO && s.adc_mv < DESK_HI) return ACC_DESK;
    return ACC_UNDEF;
  endfunction

  // MHL is sticky on removal
  function automatic void drop_accessory();
    case (cur_acc)
      ACC_HEADSET: begin
        last_path = LINE_USB;
        step_pw   = 1'b1;
        cur_acc   = ACC_UNDOCKED;
      end
      ACC_HOST: begin
        step_hm = HOST_OFF;
        cur_acc = ACC_UNDOCKED;
      end
      ACC_MHL: ;
      default: cur_acc = ACC_UNDOCKED;
    endcase
  endfunction

  function automatic result_t accessory_step(sample_t s);
    accessory_t cls;
    logic       ok;
    result_t    r;
    step_pw = 1'b0;
    step_hm = HOST_NONE;
    ok = 1'b1;
    if (regs.adc_detect_enable) begin
      if (run_len >= regs.settle_count) run_len = '0;
      cls = id_class(s);
      if (cls == prev_cls) run_len = run_len + 1'b1;
      else run_len = '0;
      prev_cls = cls;
      if (run_len < regs.settle_count) ok = 1'b0;
    end else begin
      cls = ACC_UNDOCKED;
    end
    if (ok) begin
      if (cls != ACC_UNDOCKED && cur_acc != ACC_UNDOCKED) drop_accessory();
      case (cls)
        ACC_UNDOCKED: drop_accessory();
        ACC_HEADSET: begin
          cur_acc   = cls;
          last_path = LINE_AUDIO;
          step_pw   = 1'b1;
        end
        ACC_MHL: begin
          cur_acc   = cls;
          last_path = LINE_MHL;
          step_pw   = 1'b1;
        end
        ACC_HOST: begin
          cur_acc = cls;
          step_hm = HOST_ON;
        end
        default: cur_acc = cls;
      endcase
    end
    r.settled          = ok;
    r.accessory        = cur_acc;
    r.path_write       = ok & step_pw;
    r.path_select      = last_path;
    r.host_mode_change = ok ? step_hm : HOST_NONE;
    r.irq_rearm        = ok && cur_acc != ACC_MHL;
    r.irq_active_high  = r.irq_rearm && (cur_acc != ACC_UNDOCKED || !s.id_pin);
    return r;
  endfunction

  function automatic sample_t gen_sample(accessory_t tgt);
    sample_t s;
    int      lo;
    int      hi;
    s = sample_t'($urandom);
    if (tgt == ACC_UNDOCKED) begin
      s.id_pin   = 1'b1;
      s.redetect = 1'b0;
      return s;
    end
    if (s.id_pin) s.redetect = 1'b1;
    s.adc_valid = 1'b1;
    case (tgt)
      ACC_MHL: begin
        s.adc_mv        = 12'($urandom_range(0, 99));
        s.mhl_adc_valid = 1'b1;
        s.mhl_adc_mv    = 12'($urandom_range(776, 1020));
      end
      ACC_HOST: begin
        s.adc_mv = 12'($urandom_range(0, 99));
        if ($urandom_range(0, 1)) s.mhl_adc_valid = 1'b0;
        else if ($urandom_range(0, 1)) s.mhl_adc_mv = 12'($urandom_range(0, 775));
        else s.mhl_adc_mv = 12'($urandom_range(1021, 4095));
      end
      ACC_CAR: begin
        lo = regs.car_window_low;
        hi = regs.car_window_high;
        if (hi > lo + 1) s.adc_mv = 12'($urandom_range(lo + 1, hi - 1));
      end
      ACC_HEADSET: s.adc_mv = 12'($urandom_range(371, 439));
      ACC_DESK:    s.adc_mv = 12'($urandom_range(551, 899));
      default: begin
        if ($urandom_range(0, 2) == 0) s.adc_valid = 1'b0;
        else s.adc_mv = 12'($urandom_range(900, 4095));
      end
    endcase
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (in_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic dir_row_t sample_row(bit pin, bit redo, bit av, int mv, bit mav, int mmv);
    dir_row_t row;
    row.is_reg = 1'b0;
    row.idx    = CFG_SETTLE_COUNT;
    row.val    = 0;
    row.smp    = '{pin, redo, av, 12'(mv), mav, 12'(mmv)};
    row.typed  = 1'b0;
    row.want   = IDLE_RESULT;
    return row;
  endfunction

  function automatic dir_row_t typed_row(dir_row_t row, result_t w);
    row.typed = 1'b1;
    row.want  = w;
    return row;
  endfunction

  function automatic dir_row_t reg_row(cfg_idx_t idx, int unsigned val);
    dir_row_t row;
    row        = sample_row(0, 0, 0, 0, 0, 0);
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic void check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t ns: %s expected %0d got %0d", $time, name, e, a);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, int unsigned v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(v);
    @(posedge clk);
    case (idx)
      CFG_SETTLE_COUNT:   regs.settle_count      = RUN_BITS'(v);
      CFG_ADC_DETECT_EN:  regs.adc_detect_enable = v[0];
      CFG_MHL_OVERRIDE:   regs.mhl_override      = v[0];
      CFG_MHL_SUPPORTED:  regs.mhl_supported     = v[0];
      CFG_HOST_SUPPORTED: regs.host_supported    = v[0];
      CFG_CAR_WIN_LOW:    regs.car_window_low    = sample_mv_t'(v);
      CFG_CAR_WIN_HIGH:   regs.car_window_high   = sample_mv_t'(v);
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic issue(sample_t s, bit typed, result_t w);
    int      gap;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drive    <= s;
    do @(posedge clk); while (!in_ready);
    pred = accessory_step(s);
    due_reports.push_back(typed ? w : pred);
    issued++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      out_ready <= 1'b0;
      if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(8, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t ns: result with nothing outstanding, accessory %0d", $time, accessory);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        check_field("settled", want.settled, settled);
        check_field("accessory", want.accessory, accessory);
        check_field("path_write", want.path_write, path_write);
        check_field("path_select", want.path_select, path_select);
        check_field("host_mode_change", want.host_mode_change, host_mode_change);
        check_field("irq_rearm", want.irq_rearm, irq_rearm);
        check_field("irq_active_high", want.irq_active_high, irq_active_high);
      end
    end
  end

  initial begin : stimulus
    dir_row_t   rows[$];
    accessory_t tgt;
    sample_t    s;
    int         quota;
    int         n;
    int         len;
    int         r;
    int         lo;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    drive     <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_SETTLE_COUNT;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: three equal classes in a row, then the count wraps
    rows.push_back(typed_row(sample_row(1, 0, 0, 0, 0, 0), IDLE_RESULT));
    rows.push_back(typed_row(sample_row(1, 0, 1, 4095, 1, 4095), IDLE_RESULT));
    rows.push_back(typed_row(sample_row(1, 0, 0, 0, 0, 0), UNDOCKED_PIN_HIGH));
    rows.push_back(typed_row(sample_row(1, 0, 1, 4095, 1, 4095), IDLE_RESULT));
    // settle count of zero accepts every sample
    rows.push_back(reg_row(CFG_SETTLE_COUNT, 0));
    rows.push_back(sample_row(0, 0, 1, 400, 0, 0));
    rows.push_back(sample_row(0, 0, 1, 0, 1, 776));
    rows.push_back(sample_row(1, 0, 0, 0, 0, 0));
    rows.push_back(sample_row(0, 0, 1, 99, 1, 1020));
    rows.push_back(sample_row(0, 0, 1, 0, 1, 1021));
    rows.push_back(sample_row(0, 0, 1, 50, 0, 900));
    rows.push_back(sample_row(1, 1, 1, 151, 0, 0));
    rows.push_back(sample_row(0, 0, 1, 234, 1, 4095));
    rows.push_back(sample_row(0, 0, 1, 700, 0, 0));
    rows.push_back(sample_row(0, 0, 0, 400, 1, 800));
    rows.push_back(sample_row(0, 0, 1, 4095, 1, 0));
    rows.push_back(sample_row(0, 0, 1, 100, 0, 0));
    rows.push_back(sample_row(1, 0, 1, 0, 0, 0));
    rows.push_back(sample_row(0, 0, 1, 150, 0, 0));
    rows.push_back(reg_row(CFG_MHL_OVERRIDE, 1));
    rows.push_back(sample_row(0, 0, 1, 0, 0, 0));
    rows.push_back(reg_row(CFG_MHL_SUPPORTED, 0));
    rows.push_back(sample_row(0, 0, 1, 0, 1, 900));
    rows.push_back(reg_row(CFG_MHL_OVERRIDE, 0));
    rows.push_back(reg_row(CFG_HOST_SUPPORTED, 0));
    rows.push_back(sample_row(0, 0, 1, 0, 0, 0));
    rows.push_back(reg_row(CFG_CAR_WIN_LOW, 0));
    rows.push_back(reg_row(CFG_CAR_WIN_HIGH, 4095));
    rows.push_back(sample_row(0, 0, 1, 4094, 0, 0));
    rows.push_back(sample_row(0, 0, 1, 400, 0, 0));
    rows.push_back(reg_row(CFG_ADC_DETECT_EN, 0));
    rows.push_back(sample_row(0, 0, 1, 400, 0, 0));

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        drain();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        issue(rows[i].smp, rows[i].typed, rows[i].want);
      end
    end

    while (issued < TOTAL_ITEMS) begin
      drain();
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CFG_SETTLE_COUNT, $urandom & 32'hFF0);
      else if (r == 1) write_reg(CFG_SETTLE_COUNT, ($urandom & 32'hFF0) | 15);
      else if (r == 2) write_reg(CFG_SETTLE_COUNT, $urandom_range(5, 14));
      else write_reg(CFG_SETTLE_COUNT, ($urandom & 32'hFF0) | $urandom_range(1, 4));
      write_reg(CFG_ADC_DETECT_EN, ($urandom & 32'hFFE) | ($urandom_range(0, 9) != 0));
      write_reg(CFG_MHL_OVERRIDE, ($urandom & 32'hFFE) | ($urandom_range(0, 3) == 0));
      write_reg(CFG_MHL_SUPPORTED, ($urandom & 32'hFFE) | ($urandom_range(0, 4) != 0));
      write_reg(CFG_HOST_SUPPORTED, ($urandom & 32'hFFE) | ($urandom_range(0, 4) != 0));
      r = $urandom_range(0, 9);
      if (r < 5) begin
        write_reg(CFG_CAR_WIN_LOW, CAR_LOW_RESET);
        write_reg(CFG_CAR_WIN_HIGH, CAR_HIGH_RESET);
      end else if (r < 7) begin
        lo = $urandom_range(100, 800);
        write_reg(CFG_CAR_WIN_LOW, lo);
        write_reg(CFG_CAR_WIN_HIGH, lo + $urandom_range(2, 200));
      end else if (r == 7) begin
        write_reg(CFG_CAR_WIN_LOW, 0);
        write_reg(CFG_CAR_WIN_HIGH, 4095);
      end else if (r == 8) begin
        write_reg(CFG_CAR_WIN_LOW, 4095);
        write_reg(CFG_CAR_WIN_HIGH, 0);
      end else begin
        write_reg(CFG_CAR_WIN_LOW, $urandom_range(0, 4095));
        write_reg(CFG_CAR_WIN_HIGH, $urandom_range(0, 4095));
      end
      in_burst = ($urandom_range(0, 3) == 0);
      quota = $urandom_range(40, 80);
      n = 0;
      while (n < quota && issued < TOTAL_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          issue(sample_t'($urandom), 1'b0, IDLE_RESULT);
          n++;
        end else begin
          tgt = accessory_t'($urandom_range(0, 6));
          if ($urandom_range(0, 9) < 7)
            len = int'(regs.settle_count) + $urandom_range(1, 3);
          else
            len = $urandom_range(1, int'(regs.settle_count) + 1);
          repeat (len) begin
            s = gen_sample(tgt);
            issue(s, 1'b0, IDLE_RESULT);
          end
          n += len;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", due_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
